// File: rtl/tsf_pkg.sv
// Shared types and codes for the TLV stream framer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

   // Byte roles on the result channel
   localparam logic [2:0] ROLE_TYPE     = 3'd0;
   localparam logic [2:0] ROLE_LENGTH   = 3'd1;
   localparam logic [2:0] ROLE_VALUE    = 3'd2;
   localparam logic [2:0] ROLE_LEFTOVER = 3'd3;
   localparam logic [2:0] ROLE_DISCARD  = 3'd4;

   // Frame status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_TRUNCATED = 3'd1;
   localparam logic [2:0] STAT_ZERO_LEN  = 3'd2;
   localparam logic [2:0] STAT_LEFTOVER  = 3'd3;
   localparam logic [2:0] STAT_AFTER_ERR = 3'd4;

   // Length field size register
   localparam logic [1:0] LEN_OCTETS_ONE = 2'd1;
   localparam logic [1:0] LEN_OCTETS_TWO = 2'd2;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_VALUE,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  tag_type;
      logic [15:0] tag_length;
      logic [15:0] value_offset;
      logic [7:0]  value_byte;
      logic        tag_done;
      logic [2:0]  frame_status;
      logic        frame_end;
   } rsp_type;

   // Handshake between the input register and the parse stage
   typedef struct packed {
      logic valid;
      logic take;
   } stage_ctl_type;

endpackage

`default_nettype wire

// File: rtl/tsf_in_stage.sv
// Input register of the TLV stream framer: captures one request per cycle while not stalled.
// Depends on tsf_pkg for the request type and stage handshake struct.
`timescale 1ns / 1ps
`default_nettype none

module tsf_in_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  tsf_pkg::req_type     req_payload,
   input  wire                  stage_take,
   output tsf_pkg::stage_ctl_type stage_ctl,
   output tsf_pkg::req_type     stage_data
);

   logic             valid_ff;
   logic             valid_in;
   tsf_pkg::req_type data_ff;

   // Hold while a captured request is not drained
   assign req_stall = valid_ff && !stage_take;

   always_comb begin
      if (!req_stall) begin
         valid_in = req_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_payload;
      end
   end

   assign stage_ctl.valid = valid_ff;
   assign stage_ctl.take  = stage_take;
   assign stage_data      = data_ff;

endmodule

`default_nettype wire

// File: rtl/tsf_parse_core.sv
// Tag parser state and per-byte result logic of the TLV stream framer.
// Depends on tsf_pkg for phase, codes and payload types.
`timescale 1ns / 1ps
`default_nettype none

module tsf_parse_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_wr_en,
   input  wire  [1:0]             csr_wr_data,
   input  tsf_pkg::stage_ctl_type stage_ctl,
   input  tsf_pkg::req_type       stage_data,
   output tsf_pkg::rsp_type       result
);

   tsf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         type_ff, type_in;
   logic [15:0]        len_ff, len_in;
   logic [15:0]        count_ff, count_in;
   logic               seen_ff, seen_in;
   logic [1:0]         len_octets_ff;
   logic               fire;
   logic               last;
   logic [7:0]         d;

   tsf_pkg::phase_type phase_nx;
   logic [7:0]         type_nx;
   logic [15:0]        len_nx;
   logic [15:0]        count_nx;
   logic               seen_nx;

   assign fire = stage_ctl.valid && stage_ctl.take;
   assign last = stage_data.last_byte;
   assign d    = stage_data.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_octets_ff <= tsf_pkg::LEN_OCTETS_ONE;
      end else if (csr_wr_en) begin
         len_octets_ff <= csr_wr_data;
      end
   end

   always_comb begin
      phase_nx = phase_ff;
      type_nx  = type_ff;
      len_nx   = len_ff;
      count_nx = count_ff;
      seen_nx  = seen_ff;

      result.byte_role    = tsf_pkg::ROLE_TYPE;
      result.value_offset = 16'd0;
      result.tag_done     = 1'b0;
      result.frame_status = tsf_pkg::STAT_OK;

      case (phase_ff)
         tsf_pkg::PH_TYPE: begin
            type_nx  = d;
            len_nx   = 16'd0;
            count_nx = 16'd0;
            seen_nx  = 1'b0;
            if (last) begin
               result.byte_role    = tsf_pkg::ROLE_LEFTOVER;
               result.frame_status = tsf_pkg::STAT_LEFTOVER;
            end else begin
               phase_nx = tsf_pkg::PH_LEN;
            end
         end
         tsf_pkg::PH_LEN: begin
            result.byte_role = tsf_pkg::ROLE_LENGTH;
            len_nx = {len_ff[7:0], d};
            if (len_octets_ff == tsf_pkg::LEN_OCTETS_TWO && !seen_ff) begin
               seen_nx = 1'b1;
               if (last) begin
                  result.byte_role    = tsf_pkg::ROLE_LEFTOVER;
                  result.frame_status = tsf_pkg::STAT_LEFTOVER;
               end
            end else if (len_nx == 16'd0) begin
               result.frame_status = tsf_pkg::STAT_ZERO_LEN;
               phase_nx = tsf_pkg::PH_DISCARD;
            end else if (last) begin
               result.frame_status = tsf_pkg::STAT_TRUNCATED;
            end else begin
               count_nx = 16'd0;
               phase_nx = tsf_pkg::PH_VALUE;
            end
         end
         tsf_pkg::PH_VALUE: begin
            result.byte_role    = tsf_pkg::ROLE_VALUE;
            result.value_offset = count_ff;
            count_nx = count_ff + 16'd1;
            if (count_nx == len_ff) begin
               result.tag_done = 1'b1;
               phase_nx = tsf_pkg::PH_TYPE;
            end else if (last) begin
               result.frame_status = tsf_pkg::STAT_TRUNCATED;
            end
         end
         tsf_pkg::PH_DISCARD: begin
            result.byte_role    = tsf_pkg::ROLE_DISCARD;
            result.frame_status = tsf_pkg::STAT_AFTER_ERR;
         end
         default: begin
            phase_nx = tsf_pkg::PH_TYPE;
         end
      endcase

      result.tag_type   = type_nx;
      result.tag_length = len_nx;
      result.value_byte = d;
      result.frame_end  = last;

      // Drop all tag state once the buffer closes
      if (last) begin
         phase_in = tsf_pkg::PH_TYPE;
         type_in  = 8'd0;
         len_in   = 16'd0;
         count_in = 16'd0;
         seen_in  = 1'b0;
      end else begin
         phase_in = phase_nx;
         type_in  = type_nx;
         len_in   = len_nx;
         count_in = count_nx;
         seen_in  = seen_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tsf_pkg::PH_TYPE;
         type_ff  <= 8'd0;
         len_ff   <= 16'd0;
         count_ff <= 16'd0;
         seen_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> phase_ff == tsf_pkg::PH_TYPE && !seen_ff && len_ff == 16'd0)
      else $error("tag state not cleared after end of buffer");

   a_value_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == tsf_pkg::PH_VALUE |-> len_ff != 16'd0)
      else $error("value phase with zero declared length");

   a_value_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == tsf_pkg::PH_VALUE |-> count_ff < len_ff)
      else $error("value count ran past declared length");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      fire && result.tag_done |=> phase_ff == tsf_pkg::PH_TYPE)
      else $error("tag completed but parser did not return to type code");

   a_discard_sticks: assert property (@(posedge clock) disable iff (reset)
      fire && !last && phase_ff == tsf_pkg::PH_DISCARD |=> phase_ff == tsf_pkg::PH_DISCARD)
      else $error("discard phase left before end of buffer");

endmodule

`default_nettype wire

// File: rtl/tsf_out_stage.sv
// Result register of the TLV stream framer: holds one result until taken.
// Depends on tsf_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module tsf_out_stage (
   input  wire              clock,
   input  wire              reset,
   input  wire              load_valid,
   output logic             load_ready,
   input  tsf_pkg::rsp_type load_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tsf_pkg::rsp_type rsp_payload
);

   logic             valid_ff;
   logic             valid_in;
   tsf_pkg::rsp_type data_ff;

   // Accept a new result when empty or when the current one leaves now
   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      if (load_ready) begin
         valid_in = load_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

// File: rtl/tlv_stream_framer.sv
// Top level of the TLV stream framer: input register, parser, result register.
// Depends on tsf_pkg, tsf_in_stage, tsf_parse_core and tsf_out_stage.
//
// Usage:
//   req_* carries one buffer byte per request, with last_byte on the final
//   byte. rsp_* returns exactly one result per request, in order, giving the
//   byte's role (type code, length octet, value, leftover, discarded), the
//   current tag type and length, the value offset and status codes.
//   csr_wr_en / csr_wr_data set the length field size (2 = two octets, any
//   other value = one octet); write it only while the block is idle.
// Flow:
//   A result is loaded into the result register and appears on rsp_* when its
//   request leaves the input register. One request is accepted every cycle
//   while req_stall is low; the parse state is a single register stage updated
//   as each byte moves from the input register to the result register.
// Reset:
//   Synchronous, active high. Both stages empty, parser waits for a type
//   code, length field size returns to one octet.
// Stall:
//   With rsp_stall high the result register holds its result; the input
//   register fills behind it, then req_stall rises until rsp_stall drops.
`timescale 1ns / 1ps
`default_nettype none

module tlv_stream_framer (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  tsf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tsf_pkg::rsp_type rsp_payload,
   input  wire              csr_wr_en,
   input  wire  [1:0]       csr_wr_data
);

   tsf_pkg::stage_ctl_type stage_ctl;
   tsf_pkg::req_type       stage_data;
   tsf_pkg::rsp_type       result;
   logic                   out_ready;

   tsf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .stage_take  (out_ready),
      .stage_ctl   (stage_ctl),
      .stage_data  (stage_data)
   );

   tsf_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage_ctl   (stage_ctl),
      .stage_data  (stage_data),
      .result      (result)
   );

   tsf_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (stage_ctl.valid),
      .load_ready  (out_ready),
      .load_data   (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: tb/tsf_tb_pkg.sv
// Scoreboard for the TLV stream framer bench: predicts each result from the accepted requests.
// Depends on tsf_pkg for the payload types, role and status codes and the parse phases.
`timescale 1ns / 1ps

package tsf_tb_pkg;
   import tsf_pkg::*;

   // Length field sizes that fall back to one octet
   localparam logic [1:0] LEN_OCTETS_ZERO  = 2'd0;
   localparam logic [1:0] LEN_OCTETS_THREE = 2'd3;

   class framer_scoreboard;
      logic [1:0]  length_octets;
      phase_type   parse_phase;
      logic [7:0]  cur_type;
      logic [15:0] cur_length;
      logic [15:0] value_count;
      logic        high_octet_seen;
      logic        error_seen;
      rsp_type     framed_results[$];
      int unsigned failures;

      function new();
         failures = 0;
         length_octets = LEN_OCTETS_ONE;
         clear_parse();
      endfunction

      function void clear_parse();
         parse_phase = PH_TYPE;
         cur_type = '0;
         cur_length = '0;
         value_count = '0;
         high_octet_seen = 1'b0;
         error_seen = 1'b0;
      endfunction

      function void set_length_octets(logic [1:0] octets);
         length_octets = octets;
      endfunction

      function int unsigned pending();
         return framed_results.size();
      endfunction

      // Advance the parse state by one accepted request and queue its result.
      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         e.byte_role = ROLE_TYPE;
         e.frame_status = STAT_OK;
         e.value_byte = r.data_byte;
         e.frame_end = r.last_byte;
         if (error_seen || parse_phase == PH_DISCARD) begin
            e.byte_role = ROLE_DISCARD;
            e.frame_status = STAT_AFTER_ERR;
         end else if (parse_phase == PH_TYPE) begin
            cur_type = r.data_byte;
            cur_length = '0;
            value_count = '0;
            high_octet_seen = 1'b0;
            if (r.last_byte) begin
               e.byte_role = ROLE_LEFTOVER;
               e.frame_status = STAT_LEFTOVER;
            end else begin
               parse_phase = PH_LEN;
            end
         end else if (parse_phase == PH_LEN) begin
            e.byte_role = ROLE_LENGTH;
            cur_length = {cur_length[7:0], r.data_byte};
            if (length_octets == LEN_OCTETS_TWO && !high_octet_seen) begin
               high_octet_seen = 1'b1;
               if (r.last_byte) begin
                  e.byte_role = ROLE_LEFTOVER;
                  e.frame_status = STAT_LEFTOVER;
               end
            end else if (cur_length == 16'd0) begin
               e.frame_status = STAT_ZERO_LEN;
               error_seen = 1'b1;
               parse_phase = PH_DISCARD;
            end else if (r.last_byte) begin
               e.frame_status = STAT_TRUNCATED;
            end else begin
               value_count = '0;
               parse_phase = PH_VALUE;
            end
         end else begin
            e.byte_role = ROLE_VALUE;
            e.value_offset = value_count;
            value_count = value_count + 16'd1;
            if (value_count == cur_length) begin
               e.tag_done = 1'b1;
               parse_phase = PH_TYPE;
            end else if (r.last_byte) begin
               e.frame_status = STAT_TRUNCATED;
            end
         end
         e.tag_type = cur_type;
         e.tag_length = cur_length;
         framed_results.push_back(e);
         // End of buffer: drop all parse state, keep the register
         if (r.last_byte) clear_parse();
      endfunction

      function void check_field(string field, logic [15:0] expected_val, logic [15:0] actual_val);
         if (expected_val !== actual_val) begin
            $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (framed_results.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            failures++;
            return;
         end
         e = framed_results.pop_front();
         check_field("byte_role", 16'(e.byte_role), 16'(got.byte_role));
         check_field("tag_type", 16'(e.tag_type), 16'(got.tag_type));
         check_field("tag_length", e.tag_length, got.tag_length);
         check_field("value_offset", e.value_offset, got.value_offset);
         check_field("value_byte", 16'(e.value_byte), 16'(got.value_byte));
         check_field("tag_done", 16'(e.tag_done), 16'(got.tag_done));
         check_field("frame_status", 16'(e.frame_status), 16'(got.frame_status));
         check_field("frame_end", 16'(e.frame_end), 16'(got.frame_end));
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
// Top-level bench for tlv_stream_framer: directed buffers, then random buffers.
// Depends on tsf_pkg, tsf_tb_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
   import tsf_pkg::*;
   import tsf_tb_pkg::*;

   localparam int unsigned ITEM_TARGET    = 1300;
   localparam int unsigned PHASE_ITEMS    = 220;
   localparam int unsigned QUIET_TAIL     = 200;
   localparam int unsigned SETTLE_CYCLES  = 3;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_payload;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   framer_scoreboard sb;
   req_type     buffer_bytes[$];
   int unsigned sent_count = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   bit          gap_enable = 1'b0;
   bit          stall_enable = 1'b0;

   tlv_stream_framer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Result side: stall in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Entered and left at a falling edge; valid stays high for a following request.
   task automatic send_request(input req_type r);
      bit accepted;
      if (gap_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_valid && !req_stall;
      end
      sb.note_request(r);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic put_byte(input logic [7:0] d, input logic last);
      req_type r;
      r.data_byte = d;
      r.last_byte = last;
      send_request(r);
   endtask

   // Hold off until every expected result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length_octets(input logic [1:0] octets);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= octets;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_length_octets(octets);
   endtask

   function automatic void push_byte(logic [7:0] d);
      req_type r;
      r.data_byte = d;
      r.last_byte = 1'b0;
      buffer_bytes.push_back(r);
   endfunction

   // Mostly well-formed buffers; some with a zero length, a cut, a stray header or noise.
   task automatic build_buffer();
      int unsigned kind;
      int unsigned ntags;
      int unsigned len;
      int unsigned cut;
      bit          two_octets;
      buffer_bytes.delete();
      two_octets = (sb.length_octets == LEN_OCTETS_TWO);
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         ntags = $urandom_range(1, 4);
         for (int t = 0; t < ntags; t++) begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 24) == 0) len = two_octets ? $urandom_range(1, 300)
                                                             : $urandom_range(1, 255);
            if (kind == 2 && t == ntags - 1) len = 0;
            push_byte(8'($urandom_range(0, 255)));
            if (two_octets) push_byte(len[15:8]);
            push_byte(len[7:0]);
            if (len == 0) begin
               // trailing bytes after a zero length are marked as discarded by the block
               repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
            end else begin
               repeat (len) push_byte(8'($urandom_range(0, 255)));
            end
         end
         if (kind == 3 && buffer_bytes.size() > 1) begin
            cut = $urandom_range(1, buffer_bytes.size() - 1);
            while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
         end else if (kind == 4) begin
            push_byte(8'($urandom_range(0, 255)));
            if (two_octets && $urandom_range(0, 1) == 1) push_byte(8'($urandom_range(0, 255)));
         end
      end
      buffer_bytes[buffer_bytes.size() - 1].last_byte = 1'b1;
   endtask

   initial begin
      logic [1:0]  octet_plan [4];
      int unsigned plan_idx;
      int unsigned next_switch;
      bit          tail;

      octet_plan[0] = LEN_OCTETS_TWO;
      octet_plan[1] = LEN_OCTETS_ZERO;
      octet_plan[2] = LEN_OCTETS_THREE;
      octet_plan[3] = LEN_OCTETS_ONE;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      tail = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-octet lengths: buffer of a lone type code, clean tag ending the buffer,
      // zero length, cut on the length field, cut inside a value
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b0); put_byte(8'h02, 1'b0); put_byte(8'hAA, 1'b0);
      put_byte(8'h55, 1'b1);
      put_byte(8'h10, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'hFF, 1'b1);
      put_byte(8'h20, 1'b0); put_byte(8'h05, 1'b1);
      put_byte(8'h30, 1'b0); put_byte(8'h03, 1'b0); put_byte(8'h01, 1'b0);
      put_byte(8'h02, 1'b1);

      // Two-octet lengths: cut after the high octet, zero length, clean tag
      write_length_octets(LEN_OCTETS_TWO);
      put_byte(8'h40, 1'b0); put_byte(8'h01, 1'b1);
      put_byte(8'h41, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
      put_byte(8'h77, 1'b1);
      put_byte(8'h42, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h01, 1'b0);
      put_byte(8'h99, 1'b1);

      // Size changed between the two length octets of one tag
      put_byte(8'h50, 1'b0); put_byte(8'h00, 1'b0);
      write_length_octets(LEN_OCTETS_ZERO);
      put_byte(8'h01, 1'b0); put_byte(8'hEE, 1'b1);

      plan_idx = 0;
      next_switch = sent_count;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= next_switch) begin
            write_length_octets(octet_plan[2'(plan_idx % 4)]);
            plan_idx++;
            next_switch = sent_count + PHASE_ITEMS;
            tail = (sent_count + QUIET_TAIL >= ITEM_TARGET);
            gap_enable = !tail && $urandom_range(0, 3) != 0;
            stall_enable = !tail && $urandom_range(0, 3) != 0;
         end
         build_buffer();
         foreach (buffer_bytes[i]) send_request(buffer_bytes[i]);
         if (!tail && $urandom_range(0, 40) == 0) drain_results();
      end

      gap_enable = 1'b0;
      stall_enable = 1'b0;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
